>>> sv/srr_pkg.sv
// Shared types and constants of the segmented row reducer.
// Used by the arithmetic unit and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package srr_pkg;

    // Default widths of the stored value and position fields.
    localparam int DEF_VALUE_BITS    = 32;
    localparam int DEF_POSITION_BITS = 32;

    // Fixed widths of the beat fields and of the internal datapath.
    localparam int FIELD_BITS     = 32;
    localparam int ACC_BITS       = 64;
    localparam int WIDE_BITS      = ACC_BITS + 1;
    localparam int CNT_BITS       = 32;
    localparam int STEP_BITS      = $clog2(ACC_BITS);
    localparam int ACTION_BITS    = 2;
    localparam int S_TDATA_BITS   = 2 * FIELD_BITS;
    localparam int M_TDATA_BITS   = 2 * FIELD_BITS;
    localparam int M_TUSER_BITS   = 2;
    localparam int CFG_INDEX_BITS = 2;

    // Reduction modes held in the mode register.
    typedef enum logic [1:0] {
        MODE_SUM  = 2'd0,
        MODE_MEAN = 2'd1,
        MODE_MIN  = 2'd2,
        MODE_MAX  = 2'd3
    } mode_t;

    // Kind of an input beat, carried on tuser.
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_BEGIN = 2'd0,
        ACT_ELEM  = 2'd1,
        ACT_END   = 2'd2
    } action_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEED     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SENTINEL = 2'd2;

    // Request to the shared add/subtract unit.
    typedef struct packed {
        logic [WIDE_BITS-1:0] op_a;
        logic [WIDE_BITS-1:0] op_b;
        logic                 sub;
    } alu_req_t;

endpackage : srr_pkg

`default_nettype wire

>>> sv/segmented_row_reducer.sv
// Segmented row reducer: begin-row beats are taken in the idle state, element beats pass
// through the element state. End-row beats go to the row-end state for sum, min and max;
// for mean they first take a magnitude step, 64 restoring divide steps and a sign step,
// all on the shared 65-bit add/subtract unit; row end waits for a free output register.
// aresetn is synchronous and active low; it clears the control and row state registers only.
// Depends on srr_pkg and srr_alu.
`timescale 1ns / 1ps
`default_nettype none

module segmented_row_reducer #(
    parameter int VALUE_BITS    = srr_pkg::DEF_VALUE_BITS,
    parameter int POSITION_BITS = srr_pkg::DEF_POSITION_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input beats.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: sample_value [31:0], source_position [63:32]
    input  logic [srr_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // s_tuser: action [1:0]
    input  logic [srr_pkg::ACTION_BITS-1:0]     s_tuser,
    // Result beats.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: row_result [31:0], winner_position [63:32]
    output logic [srr_pkg::M_TDATA_BITS-1:0]    m_tdata,
    // m_tuser: row_was_empty [0], saturated [1]
    output logic [srr_pkg::M_TUSER_BITS-1:0]    m_tuser,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [srr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [srr_pkg::FIELD_BITS-1:0]      cfg_data
);
    import srr_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ELEM = 6'b000010,
        ST_PREP = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_POST = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    localparam logic signed [VALUE_BITS-1:0] VMAX_V = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VMIN_V = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(ACC_BITS - 1);

    // Registers.
    state_t                         state_reg, state_next;
    mode_t                          mode_reg, mode_next;
    logic                           seed_reg, seed_next;
    logic [POSITION_BITS-1:0]       sentinel_reg, sentinel_next;
    logic [ACC_BITS-1:0]            acc_reg, acc_next;
    logic [CNT_BITS-1:0]            count_reg, count_next;
    logic [POSITION_BITS-1:0]       best_reg, best_next;
    logic                           winner_reg, winner_next;
    logic signed [VALUE_BITS-1:0]   val_reg, val_next;
    logic [POSITION_BITS-1:0]       pos_reg, pos_next;
    logic [ACC_BITS-1:0]            quot_reg, quot_next;
    logic [CNT_BITS-1:0]            rem_reg, rem_next;
    logic [STEP_BITS-1:0]           step_reg, step_next;
    logic                           neg_reg, neg_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [FIELD_BITS-1:0]          out_result_reg, out_result_next;
    logic [FIELD_BITS-1:0]          out_pos_reg, out_pos_next;
    logic                           out_empty_reg, out_empty_next;
    logic                           out_sat_reg, out_sat_next;

    // Combinational helpers.
    action_t                        in_action;
    logic signed [VALUE_BITS-1:0]   in_value;
    logic [POSITION_BITS-1:0]       in_pos;
    logic [ACC_BITS-1:0]            seed_init;
    logic [CNT_BITS-1:0]            divisor;
    logic [CNT_BITS:0]              div_shifted;
    logic [ACC_BITS-1:0]            acc_sel;
    logic [ACC_BITS-VALUE_BITS:0]   acc_top;
    logic                           acc_in_range;
    logic signed [VALUE_BITS-1:0]   acc_clamped;
    logic                           out_free;
    alu_req_t                       alu_req;
    logic [WIDE_BITS-1:0]           alu_result;

    // Shared arithmetic unit.
    srr_alu u_alu (
        .req    (alu_req),
        .result (alu_result)
    );

    // Beat field extraction.
    assign in_action = action_t'(s_tuser);
    assign in_value  = s_tdata[VALUE_BITS-1:0];
    assign in_pos    = s_tdata[FIELD_BITS +: POSITION_BITS];

    // Start value of the accumulator on a begin-row beat.
    always_comb begin
        unique case (mode_reg)
            MODE_MEAN: seed_init = '0;
            MODE_SUM:  seed_init = seed_reg ? ACC_BITS'(in_value) : '0;
            MODE_MIN:  seed_init = seed_reg ? ACC_BITS'(in_value) : ACC_BITS'(VMAX_V);
            MODE_MAX:  seed_init = seed_reg ? ACC_BITS'(in_value) : ACC_BITS'(VMIN_V);
            default:   seed_init = '0;
        endcase
    end

    // Divisor of the mean: the element count, at least one.
    assign divisor     = (count_reg == '0) ? CNT_BITS'(1) : count_reg;
    assign div_shifted = {rem_reg, quot_reg[ACC_BITS-1]};

    // Value reported at row end, clamped to the value range.
    always_comb begin
        if ((mode_reg == MODE_MIN || mode_reg == MODE_MAX) && !winner_reg && !seed_reg) begin
            acc_sel = '0;
        end else begin
            acc_sel = acc_reg;
        end
    end
    assign acc_top      = acc_sel[ACC_BITS-1:VALUE_BITS-1];
    assign acc_in_range = (&acc_top) | ~(|acc_top);
    assign acc_clamped  = acc_in_range ? acc_sel[VALUE_BITS-1:0]
                                       : (acc_sel[ACC_BITS-1] ? VMIN_V : VMAX_V);

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer and datapath next values.
    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        seed_next       = seed_reg;
        sentinel_next   = sentinel_reg;
        acc_next        = acc_reg;
        count_next      = count_reg;
        best_next       = best_reg;
        winner_next     = winner_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        neg_next        = neg_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_result_next = out_result_reg;
        out_pos_next    = out_pos_reg;
        out_empty_next  = out_empty_reg;
        out_sat_next    = out_sat_reg;
        alu_req         = '0;

        // Configuration writes.
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MODE:     mode_next     = mode_t'(cfg_data[1:0]);
                REG_SEED:     seed_next     = cfg_data[0];
                REG_SENTINEL: sentinel_next = cfg_data[POSITION_BITS-1:0];
                default:      ;
            endcase
        end

        // The output register empties when its beat is taken.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_action)
                        ACT_BEGIN: begin
                            count_next  = '0;
                            best_next   = sentinel_reg;
                            winner_next = 1'b0;
                            acc_next    = seed_init;
                        end
                        ACT_ELEM: begin
                            val_next   = in_value;
                            pos_next   = in_pos;
                            state_next = ST_ELEM;
                        end
                        ACT_END: begin
                            state_next = (mode_reg == MODE_MEAN) ? ST_PREP : ST_DONE;
                        end
                        default: ;
                    endcase
                end
            end

            // One element: saturating add or strict compare on the shared unit.
            ST_ELEM: begin
                if (count_reg != '1) begin
                    count_next = count_reg + CNT_BITS'(1);
                end
                unique case (mode_reg) inside
                    MODE_SUM, MODE_MEAN: begin
                        alu_req.op_a = {acc_reg[ACC_BITS-1], acc_reg};
                        alu_req.op_b = WIDE_BITS'(val_reg);
                        alu_req.sub  = 1'b0;
                        if (alu_result[WIDE_BITS-1] != alu_result[ACC_BITS-1]) begin
                            acc_next = alu_result[WIDE_BITS-1] ? ACC_MIN : ACC_MAX;
                        end else begin
                            acc_next = alu_result[ACC_BITS-1:0];
                        end
                    end
                    MODE_MIN, MODE_MAX: begin
                        // The sign of the difference tells whether the element wins.
                        if (mode_reg == MODE_MIN) begin
                            alu_req.op_a = WIDE_BITS'(val_reg);
                            alu_req.op_b = {acc_reg[ACC_BITS-1], acc_reg};
                        end else begin
                            alu_req.op_a = {acc_reg[ACC_BITS-1], acc_reg};
                            alu_req.op_b = WIDE_BITS'(val_reg);
                        end
                        alu_req.sub = 1'b1;
                        if (alu_result[WIDE_BITS-1]) begin
                            acc_next    = ACC_BITS'(val_reg);
                            best_next   = pos_reg;
                            winner_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
                state_next = ST_IDLE;
            end

            // Magnitude of the sum ahead of the unsigned divide.
            ST_PREP: begin
                alu_req.op_a = '0;
                alu_req.op_b = {acc_reg[ACC_BITS-1], acc_reg};
                alu_req.sub  = acc_reg[ACC_BITS-1];
                quot_next    = alu_result[ACC_BITS-1:0];
                neg_next     = acc_reg[ACC_BITS-1];
                rem_next     = '0;
                step_next    = '0;
                state_next   = ST_DIV;
            end

            // One restoring divide step per cycle, quotient shifts in from the bottom.
            ST_DIV: begin
                alu_req.op_a = WIDE_BITS'(div_shifted);
                alu_req.op_b = WIDE_BITS'(divisor);
                alu_req.sub  = 1'b1;
                rem_next     = alu_result[WIDE_BITS-1] ? div_shifted[CNT_BITS-1:0]
                                                       : alu_result[CNT_BITS-1:0];
                quot_next    = {quot_reg[ACC_BITS-2:0], ~alu_result[WIDE_BITS-1]};
                step_next    = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_LAST) begin
                    state_next = ST_POST;
                end
            end

            // Restore the sign; truncation is toward zero.
            ST_POST: begin
                alu_req.op_a = '0;
                alu_req.op_b = {1'b0, quot_reg};
                alu_req.sub  = neg_reg;
                acc_next     = alu_result[ACC_BITS-1:0];
                state_next   = ST_DONE;
            end

            // Hand the row result to the output register and clear the row.
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    out_result_next = FIELD_BITS'(acc_clamped);
                    out_empty_next  = (count_reg == '0);
                    out_sat_next    = (mode_reg == MODE_SUM) && !acc_in_range;
                    if (mode_reg == MODE_MIN || mode_reg == MODE_MAX) begin
                        out_pos_next = winner_reg ? FIELD_BITS'(best_reg)
                                                  : FIELD_BITS'(sentinel_reg);
                    end else begin
                        out_pos_next = '0;
                    end
                    acc_next    = '0;
                    count_next  = '0;
                    best_next   = '0;
                    winner_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control and row state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_SUM;
            seed_reg     <= 1'b0;
            sentinel_reg <= '0;
            acc_reg      <= '0;
            count_reg    <= '0;
            best_reg     <= '0;
            winner_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            seed_reg     <= seed_next;
            sentinel_reg <= sentinel_next;
            acc_reg      <= acc_next;
            count_reg    <= count_next;
            best_reg     <= best_next;
            winner_reg   <= winner_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Operand, divider and output payload registers.
    always_ff @(posedge aclk) begin
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        quot_reg       <= quot_next;
        rem_reg        <= rem_next;
        step_reg       <= step_next;
        neg_reg        <= neg_next;
        out_result_reg <= out_result_next;
        out_pos_reg    <= out_pos_next;
        out_empty_reg  <= out_empty_next;
        out_sat_reg    <= out_sat_next;
    end

    // Port drive.
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {out_pos_reg, out_result_reg};
    assign m_tuser   = {out_sat_reg, out_empty_reg};

`ifndef SYNTH
    // The divider runs its full number of steps before leaving.
    a_div_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && step_reg != STEP_LAST) |=> (state_reg == ST_DIV))
        else $error("divider left before its last step");

    // The partial remainder always stays below the divisor.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < divisor))
        else $error("divider remainder not below divisor");

    // A result beat only appears after the row-end state.
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result beat raised outside row end");

    // An accepted end-row beat always starts the row-end sequence.
    a_end_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && in_action == ACT_END) |=> (state_reg != ST_IDLE))
        else $error("end-row beat did not start row end");
`endif

endmodule : segmented_row_reducer

`default_nettype wire

>>> sv/srr_alu.sv
// Shared 65-bit add/subtract unit of the segmented row reducer.
// Depends on srr_pkg for the request type and the datapath width.
`timescale 1ns / 1ps
`default_nettype none

module srr_alu (
    input  srr_pkg::alu_req_t              req,
    output logic [srr_pkg::WIDE_BITS-1:0]  result
);
    import srr_pkg::*;

    logic [WIDE_BITS-1:0] op_b_eff;

    // Subtraction is addition of the inverted operand with a carry in.
    assign op_b_eff = req.sub ? ~req.op_b : req.op_b;
    assign result   = req.op_a + op_b_eff + WIDE_BITS'(req.sub);

endmodule : srr_alu

`default_nettype wire
